[hw/rtl/chat_markup_stripper_macros.svh]
// Assertion macros shared by the checker of the markup stripper.
`ifndef CHAT_MARKUP_STRIPPER_MACROS_SVH
`define CHAT_MARKUP_STRIPPER_MACROS_SVH

// Same-cycle implication, reported by $error.
`define CMS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("chat_markup_stripper: assertion failed");

// Next-cycle implication, reported by $error.
`define CMS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("chat_markup_stripper: assertion failed");

`endif

[hw/rtl/cms_pkg.sv]
// Shared constants, types and helpers of the chat markup stripper.
package cms_pkg;

  localparam int WIN_DEPTH   = 7;
  localparam int FILL_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Skip mode codes
  localparam logic [1:0] SKIP_NONE = 2'd0;
  localparam logic [1:0] SKIP_TAG  = 2'd1;
  localparam logic [1:0] SKIP_ESC  = 2'd2;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B; // '['
  localparam logic [7:0] CH_M    = 8'h6D; // 'm'
  localparam logic [7:0] CH_GT   = 8'h3E; // '>'
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_UA   = 8'h41; // 'A'
  localparam logic [7:0] CH_UZ   = 8'h5A; // 'Z'
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Tag openers and closers, lower case, first character in the top byte
  localparam logic [47:0] TAG_FONT_OPEN  = "<font ";
  localparam logic [47:0] TAG_FONT_CLOSE = "</font";
  localparam logic [47:0] TAG_FADE_OPEN  = "<fade ";
  localparam logic [55:0] TAG_FADE_CLOSE = "</fade>";
  localparam logic [39:0] TAG_ALT_OPEN   = "<alt ";
  localparam logic [47:0] TAG_ALT_CLOSE  = "</alt>";

  // One queued action: a byte to send, optionally followed by an LF,
  // or the bare end marker.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       end_mark;
    logic       add_lf;
  } cms_cmd_t;

  function automatic logic [7:0] fold_case(logic [7:0] b);
    if (b >= CH_UA && b <= CH_UZ) begin
      return b + CASE_OFS;
    end
    return b;
  endfunction

endpackage

[hw/rtl/cms_if.sv]
// Valid/ready channel interfaces for message bytes and filtered beats.
interface cms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface cms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output out_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

[hw/rtl/cms_front.sv]
// Front end: lookahead window, tag and escape matching, action issue.
module cms_front (
  input  logic              clk,
  input  logic              rst,
  cms_in_if.sink            message,
  input  logic              cmd_room,
  output logic              cmd_push,
  output cms_pkg::cms_cmd_t cmd
);
  import cms_pkg::*;

  logic [7:0]        win [WIN_DEPTH];
  logic [7:0]        fw  [WIN_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [1:0]        skip;
  logic [1:0]        skip_next;
  logic              flush;
  logic              accept;
  logic              decide;
  logic              finish;
  logic              has_next;
  logic              tag_hit;
  logic              esc_hit;
  logic              emit;
  logic              add_lf;

  assign message.ready = !flush && (fill != FILL_W'(WIN_DEPTH));
  assign accept        = message.valid && message.ready;
  assign decide        = cmd_room && ((fill == FILL_W'(WIN_DEPTH)) ||
                                      (flush && fill != '0));
  assign finish        = cmd_room && flush && (fill == '0);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      fw[i] = fold_case(win[i]);
    end
  end

  assign has_next = fill >= FILL_W'(2);

  assign tag_hit =
    (fill >= FILL_W'(6) && {fw[0], fw[1], fw[2], fw[3], fw[4], fw[5]} == TAG_FONT_OPEN)  ||
    (fill >= FILL_W'(6) && {fw[0], fw[1], fw[2], fw[3], fw[4], fw[5]} == TAG_FONT_CLOSE) ||
    (fill >= FILL_W'(6) && {fw[0], fw[1], fw[2], fw[3], fw[4], fw[5]} == TAG_FADE_OPEN)  ||
    (fill >= FILL_W'(7) &&
     {fw[0], fw[1], fw[2], fw[3], fw[4], fw[5], fw[6]} == TAG_FADE_CLOSE)                 ||
    (fill >= FILL_W'(5) && {fw[0], fw[1], fw[2], fw[3], fw[4]} == TAG_ALT_OPEN)          ||
    (fill >= FILL_W'(6) && {fw[0], fw[1], fw[2], fw[3], fw[4], fw[5]} == TAG_ALT_CLOSE);

  assign esc_hit = (win[0] == CH_ESC) && has_next && (win[1] == CH_LBR);

  // Classify the head byte
  always_comb begin
    skip_next = skip;
    emit      = 1'b0;
    add_lf    = 1'b0;
    unique case (skip)
      SKIP_TAG: begin
        if (win[0] == CH_GT) skip_next = SKIP_NONE;
      end
      SKIP_ESC: begin
        if (win[0] == CH_M) skip_next = SKIP_NONE;
      end
      SKIP_NONE: begin
        if (tag_hit) begin
          skip_next = SKIP_TAG;
        end else if (esc_hit) begin
          skip_next = SKIP_ESC;
        end else begin
          emit   = 1'b1;
          add_lf = (win[0] == CH_CR) && (!has_next || win[1] != CH_LF);
        end
      end
      default: skip_next = SKIP_NONE;
    endcase
  end

  assign cmd_push = (decide && emit) || finish;

  always_comb begin
    if (finish) begin
      cmd = '{data: 8'h00, present: 1'b0, end_mark: 1'b1, add_lf: 1'b0};
    end else begin
      cmd = '{data: win[0], present: 1'b1, end_mark: 1'b0, add_lf: add_lf};
    end
  end

  // Window contents: append on accept, shift out the head on a decision
  always_ff @(posedge clk) begin
    if (accept) begin
      win[fill] <= message.in_byte;
    end else if (decide) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      skip  <= SKIP_NONE;
      flush <= 1'b0;
    end else begin
      if (accept) begin
        fill  <= fill + FILL_W'(1);
        flush <= message.last_byte;
      end else if (decide) begin
        fill <= fill - FILL_W'(1);
        skip <= skip_next;
      end else if (finish) begin
        flush <= 1'b0;
        skip  <= SKIP_NONE;
      end
    end
  end

endmodule

[hw/rtl/cms_queue.sv]
// Short action queue between the front end and the output stage.
module cms_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cms_pkg::cms_cmd_t push_cmd,
  output logic              room,
  input  logic              pop,
  output logic              head_valid,
  output cms_pkg::cms_cmd_t head_cmd
);
  import cms_pkg::*;

  cms_cmd_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign room       = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/cms_back.sv]
// Output stage: carries out queued actions and registers each beat.
module cms_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cms_pkg::cms_cmd_t head_cmd,
  output logic              pop,
  cms_out_if.source         filtered
);
  import cms_pkg::*;

  logic       beat_valid;
  logic [7:0] beat_byte;
  logic       beat_present;
  logic       beat_end;
  logic       lf_pending;
  logic       load;

  assign load = !beat_valid || filtered.ready;
  assign pop  = load && !lf_pending && head_valid;

  assign filtered.valid          = beat_valid;
  assign filtered.out_byte       = beat_byte;
  assign filtered.byte_present   = beat_present;
  assign filtered.end_of_message = beat_end;

  always_ff @(posedge clk) begin
    if (load) begin
      if (lf_pending) begin
        beat_byte    <= CH_LF;
        beat_present <= 1'b1;
        beat_end     <= 1'b0;
      end else begin
        beat_byte    <= head_cmd.data;
        beat_present <= head_cmd.present;
        beat_end     <= head_cmd.end_mark;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
      lf_pending <= 1'b0;
    end else if (load) begin
      if (lf_pending) begin
        beat_valid <= 1'b1;
        lf_pending <= 1'b0;
      end else begin
        beat_valid <= head_valid;
        lf_pending <= head_valid && head_cmd.add_lf;
      end
    end
  end

endmodule

[hw/rtl/chat_markup_stripper.sv]
// Decision: once six later bytes are in, or at the flush; its action is registered in
//   the queue, then in the output beat. Input: the front end alternates between a byte
//   and a head decision; at the flush, one decision per cycle while the queue has room.
// Last byte: up to seven head decisions, then the end marker; a CR with an
//   added LF takes two output beats. Synchronous reset clears window fill,
//   skip mode, queue and the output stage; window bytes are not reset.
module chat_markup_stripper (
  input  logic      clk,
  input  logic      rst,
  cms_in_if.sink    message,
  cms_out_if.source filtered
);
  import cms_pkg::*;

  // Actions travelling from the front end to the output stage
  cms_cmd_t front_cmd;
  cms_cmd_t head_cmd;
  logic     front_push;
  logic     queue_room;
  logic     head_valid;
  logic     back_pop;

  // Front end: hold the seven-byte window, match tag openers, closers and escapes
  // at its head, and issue one action per kept byte plus the end marker.
  cms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .message  (message),
    .cmd_room (queue_room),
    .cmd_push (front_push),
    .cmd      (front_cmd)
  );

  // Queue: decouple decisions from output stalls.
  cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_push),
    .push_cmd   (front_cmd),
    .room       (queue_room),
    .pop        (back_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: turn each action into one or two registered beats.
  cms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (back_pop),
    .filtered   (filtered)
  );

endmodule

[hw/rtl/cms_checker.sv]
// Port-level checker for the chat markup stripper, with its bind.
`include "chat_markup_stripper_macros.svh"

module cms_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_present,
  input logic       out_end
);

  // A stalled beat holds
  `CMS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_present) && $stable(out_end))
  // Only the end marker lacks a byte
  `CMS_ASSERT_IMPLY(a_marker_kind, clk, rst, out_valid, out_present != out_end)
  // No new message byte while the window flushes
  `CMS_ASSERT_NEXT(a_flush_stall, clk, rst, in_valid && in_ready && in_last, !in_ready)
  // Reset leaves the block empty and ready
  `CMS_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !out_valid && in_ready)

endmodule

bind chat_markup_stripper cms_checker u_cms_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (message.valid),
  .in_ready    (message.ready),
  .in_last     (message.last_byte),
  .out_valid   (filtered.valid),
  .out_ready   (filtered.ready),
  .out_byte    (filtered.out_byte),
  .out_present (filtered.byte_present),
  .out_end     (filtered.end_of_message)
);
